// ===== design/sb12_pkg.sv =====
// Shared types, constants and helpers for the signed base-12 formatter.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package sb12_pkg;

  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned DIGITS         = 18;  // base-12 digits of 2^63
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned PTR_W          = 5;   // indexes DIGITS entries
  localparam int unsigned BITS_PER_CYCLE = 4;
  localparam int unsigned CONV_CYCLES    = VALUE_W / BITS_PER_CYCLE;
  localparam int unsigned CONV_CNT_W     = 4;

  localparam logic [DIGIT_W-1:0] ADJ_THRESH = 4'd6;
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = 4'd2;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_TEN   = 8'h61;
  localparam logic [7:0] CHAR_ELVN  = 8'h62;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // One queue word: sign and magnitude of a number waiting for conversion.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_SIGN,
    ST_DIGS
  } back_state_e;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + {4'b0000, d};
    end else if (d == DIGIT_TEN) begin
      c = CHAR_TEN;
    end else begin
      c = CHAR_ELVN;
    end
    return c;
  endfunction

endpackage

// ===== design/signed_base12_formatter_unit.sv =====
// Each accepted signed 64-bit word is emitted as base-12 ASCII text, most
// significant character first, '-' ahead of negative values, 'a' and 'b' for
// ten and eleven, last_o high on the final character; the most negative value
// prints as the magnitude 2^63. Per number the back end loads the word,
// converts it (four bits a cycle through 18 digit cells), locates the leading
// digit and then emits its characters, 1 to 19 of them, one at a time as the
// output register frees up, waiting there while the receiver stalls.
// A two-word queue lets the input side take up to two numbers ahead, and
// the output register lets the block keep working while a character waits.
// Top level; instantiates sb12_front, sb12_queue and sb12_back from sb12_pkg.
`timescale 1ns / 1ps

module signed_base12_formatter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [63:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         char_code_o,
  output logic               last_o
);

  sb12_pkg::entry_t push_entry;
  sb12_pkg::entry_t head_entry;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;

  sb12_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  sb12_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .entry_o (head_entry)
  );

  sb12_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

`ifndef SYNTHESIS
  // A sign character never ends a number.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && char_code_o == sb12_pkg::CHAR_MINUS) |-> !last_o)
    else $error("sign character flagged as last");

  // Only digit, letter and sign codes leave the block.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((char_code_o >= sb12_pkg::CHAR_ZERO &&
                      char_code_o <= sb12_pkg::CHAR_NINE) ||
                     char_code_o == sb12_pkg::CHAR_TEN ||
                     char_code_o == sb12_pkg::CHAR_ELVN ||
                     char_code_o == sb12_pkg::CHAR_MINUS))
    else $error("illegal character code");

  // The queue fills only after a word was pushed.
  a_stall_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(push))
    else $error("input stall rose without a push");
`endif

endmodule

// ===== design/sb12_front.sv =====
// Front end: takes input words, splits them into sign and magnitude.
// Uses sb12_pkg; feeds sb12_queue.
`timescale 1ns / 1ps

module sb12_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [63:0]            value_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output sb12_pkg::entry_t              entry_o
);

  logic neg;

  assign neg        = value_i[63];
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Two's complement negate; the most negative value comes out as 2^63 unsigned.
  assign entry_o.neg = neg;
  assign entry_o.mag = neg ? (64'd0 - 64'(value_i)) : 64'(value_i);

endmodule

// ===== design/sb12_queue.sv =====
// Two-word queue between front end and back end.
// Uses sb12_pkg for the word type.
`timescale 1ns / 1ps

module sb12_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sb12_pkg::entry_t entry_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output sb12_pkg::entry_t entry_o
);

  sb12_pkg::entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== design/sb12_back.sv =====
// Back end: shift-and-adjust conversion to base-12 digits, then character output.
// Uses sb12_pkg; pops words from sb12_queue and drives the output register.
`timescale 1ns / 1ps

module sb12_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  sb12_pkg::entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       char_code_o,
  output logic             last_o
);

  localparam int unsigned ND = sb12_pkg::DIGITS;
  localparam int unsigned DW = sb12_pkg::DIGIT_W;

  sb12_pkg::back_state_e              state_q, state_d;
  logic [DW-1:0]                      dig_q [ND];
  logic [DW-1:0]                      dig_d [ND];
  logic [DW-1:0]                      conv_dig [ND];
  logic [sb12_pkg::VALUE_W-1:0]       sh_q, sh_d, conv_sh;
  logic [sb12_pkg::CONV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [sb12_pkg::PTR_W-1:0]         ptr_q, ptr_d, msd;
  logic                               neg_q, neg_d;
  logic                               ov_q, ov_d;
  logic [7:0]                         ch_q, ch_d;
  logic                               last_q, last_d;
  logic                               slot_free;

  assign slot_free   = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;
  assign char_code_o = ch_q;
  assign last_o      = last_q;

  // Four shift-and-adjust steps: a digit of six or more gets two added so the
  // doubling carries out of the four-bit cell exactly when it reaches twelve.
  always_comb begin
    logic [DW-1:0]                tmp [ND];
    logic [DW-1:0]                adj [ND];
    logic [sb12_pkg::VALUE_W-1:0] sh;
    logic                         cin;
    tmp = dig_q;
    sh  = sh_q;
    adj = dig_q;
    cin = 1'b0;
    for (int s = 0; s < int'(sb12_pkg::BITS_PER_CYCLE); s++) begin
      cin = sh[sb12_pkg::VALUE_W-1];
      for (int i = 0; i < int'(ND); i++) begin
        adj[i] = (tmp[i] >= sb12_pkg::ADJ_THRESH) ? (tmp[i] + sb12_pkg::ADJ_ADD) : tmp[i];
      end
      for (int i = 0; i < int'(ND); i++) begin
        if (i == 0) begin
          tmp[i] = {adj[i][DW-2:0], cin};
        end else begin
          tmp[i] = {adj[i][DW-2:0], adj[i-1][DW-1]};
        end
      end
      sh = {sh[sb12_pkg::VALUE_W-2:0], 1'b0};
    end
    conv_dig = tmp;
    conv_sh  = sh;
  end

  // Highest nonzero digit; zero leaves a single digit.
  always_comb begin
    msd = '0;
    for (int i = 0; i < int'(ND); i++) begin
      if (dig_q[i] != '0) begin
        msd = sb12_pkg::PTR_W'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    neg_d   = neg_q;
    ov_d    = ov_q && out_stall_i;
    ch_d    = ch_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    unique case (state_q)
      sb12_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          sh_d  = entry_i.mag;
          neg_d = entry_i.neg;
          cnt_d = sb12_pkg::CONV_CNT_W'(sb12_pkg::CONV_CYCLES - 1);
          for (int i = 0; i < int'(ND); i++) begin
            dig_d[i] = '0;
          end
          state_d = sb12_pkg::ST_CONV;
        end
      end
      sb12_pkg::ST_CONV: begin
        dig_d = conv_dig;
        sh_d  = conv_sh;
        if (cnt_q == '0) begin
          state_d = sb12_pkg::ST_FIND;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      sb12_pkg::ST_FIND: begin
        ptr_d   = msd;
        state_d = neg_q ? sb12_pkg::ST_SIGN : sb12_pkg::ST_DIGS;
      end
      sb12_pkg::ST_SIGN: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          ch_d    = sb12_pkg::CHAR_MINUS;
          last_d  = 1'b0;
          state_d = sb12_pkg::ST_DIGS;
        end
      end
      sb12_pkg::ST_DIGS: begin
        if (slot_free) begin
          ov_d   = 1'b1;
          ch_d   = sb12_pkg::digit_char(dig_q[ptr_q]);
          last_d = (ptr_q == '0);
          if (ptr_q == '0) begin
            state_d = sb12_pkg::ST_IDLE;
          end else begin
            ptr_d = ptr_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = sb12_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sb12_pkg::ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    sh_q   <= sh_d;
    cnt_q  <= cnt_d;
    ptr_q  <= ptr_d;
    neg_q  <= neg_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

endmodule

// ===== tb/sb12_stream_checker.sv =====
// Stream checker for the signed base-12 formatter: watches both channels,
// predicts the ASCII text of every accepted word and compares each character.
// Depends on sb12_pkg for the digit count and the character constants.
`timescale 1ns / 1ps

module sb12_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_i,
  output int          error_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
  } text_char_t;

  text_char_t expected_chars[$];
  text_char_t want;
  int         mismatch_count = 0;

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Push the characters that one word must produce: sign, then digits
  // from the most significant down.
  task automatic push_expected_text(input logic [63:0] value);
    logic [63:0]  mag;
    logic         neg;
    logic [3:0]   digits [sb12_pkg::DIGITS];
    int unsigned  n;
    text_char_t   c;
    neg = value[63];
    mag = neg ? (64'd0 - value) : value;
    n   = 0;
    if (mag == 64'd0) begin
      digits[0] = 4'd0;
      n = 1;
    end else begin
      while (mag != 64'd0 && n < sb12_pkg::DIGITS) begin
        digits[n] = 4'(mag % 64'd12);
        mag = mag / 64'd12;
        n++;
      end
    end
    if (neg) begin
      c.code    = sb12_pkg::CHAR_MINUS;
      c.is_last = 1'b0;
      expected_chars.push_back(c);
    end
    while (n > 0) begin
      n--;
      if (digits[n] < 4'd10) begin
        c.code = sb12_pkg::CHAR_ZERO + {4'b0000, digits[n]};
      end else if (digits[n] == 4'd10) begin
        c.code = sb12_pkg::CHAR_TEN;
      end else begin
        c.code = sb12_pkg::CHAR_ELVN;
      end
      c.is_last = (n == 0);
      expected_chars.push_back(c);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        push_expected_text(value_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %h last %b", char_code_i, last_i));
        end else begin
          want = expected_chars.pop_front();
          if (char_code_i !== want.code) begin
            report_mismatch($sformatf("char_code %h, want %h", char_code_i, want.code));
          end
          if (last_i !== want.is_last) begin
            report_mismatch($sformatf("last %b, want %b (char %h)",
                                      last_i, want.is_last, want.code));
          end
        end
      end
    end
    error_count_o <= mismatch_count;
    pending_o     <= expected_chars.size();
  end

endmodule

// ===== tb/tb_signed_base12_formatter_unit.sv =====
// Testbench top for signed_base12_formatter_unit: drives directed and random
// words with random gaps and output stalls, and gives the verdict.
// Depends on the block, sb12_pkg and sb12_stream_checker.
`timescale 1ns / 1ps

module tb_signed_base12_formatter_unit;

  localparam int RANDOM_WORDS = 90;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic signed [63:0] value_i     = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [7:0]         char_code_o;
  logic               last_o;
  int                 error_count;
  int                 pending;
  int                 cycle_count = 0;

  signed_base12_formatter_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  sb12_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .char_code_i   (char_code_o),
    .last_i        (last_o),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d chars outstanding", cycle_count, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] pow12(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) begin
      p = p * 64'd12;
    end
    return p;
  endfunction

  function automatic logic [63:0] random_word();
    logic [63:0] v;
    int          kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      v = {$urandom, $urandom};
    end else if (kind < 6) begin
      v = 64'($urandom_range(0, 300));
      if ($urandom_range(0, 1)) v = 64'd0 - v;
    end else if (kind < 9) begin
      // land on digit-count boundaries
      v = pow12($urandom_range(0, 17)) + 64'($urandom_range(0, 2)) - 64'd1;
      if ($urandom_range(0, 1)) v = 64'd0 - v;
    end else begin
      case ($urandom_range(0, 3))
        0: v = 64'h7fff_ffff_ffff_ffff;
        1: v = 64'h8000_0000_0000_0000;
        2: v = 64'h8000_0000_0000_0001;
        default: v = 64'd0;
      endcase
    end
    return v;
  endfunction

  // Present one word and hold it until accepted; keep valid high across
  // back-to-back words.
  task automatic send_word(input logic [63:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Receiver: alternate stall bursts and open stretches.
  initial begin
    int stall_len;
    int run_len;
    @(posedge rst_ni);
    forever begin
      stall_len = pick_gap();
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 20);
      repeat (run_len) @(posedge clk_i);
    end
  end

  initial begin
    logic [63:0] directed[$];
    directed = '{
      64'd0, 64'd1, 64'hffff_ffff_ffff_ffff, 64'd10, 64'd11, 64'd12,
      64'hffff_ffff_ffff_fff5, 64'hffff_ffff_ffff_fff4, 64'd143, 64'd144,
      64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      pow12(17), pow12(17) - 64'd1, 64'd0 - pow12(17),
      64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'd0, 64'd1_000_000
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) begin
      send_word(directed[i]);
    end
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      send_word(random_word());
    end
    in_valid_i <= 1'b0;
    value_i    <= {$urandom, $urandom};
    // let the checker count the final word before watching pending
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sb12_pkg.sv
design/sb12_front.sv
design/sb12_queue.sv
design/sb12_back.sv
design/signed_base12_formatter_unit.sv
tb/sb12_stream_checker.sv
tb/tb_signed_base12_formatter_unit.sv
